[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cons must hold in the same cycle as ante
`define RS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define RS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RS_ASSERT_SAME(lbl, ante, cons, msg)
`define RS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[src/rs_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rs_pkg
// Shared types and constants for the rectangle difference block.
// ---------------------------------------------------------------------------
package rs_pkg;

  localparam int NUM_STRIPS = 4;
  localparam int CNT_W      = 3;

  // strip slots, in output order
  localparam logic [1:0] PC_TOP    = 2'd0;
  localparam logic [1:0] PC_LEFT   = 2'd1;
  localparam logic [1:0] PC_BOTTOM = 2'd2;
  localparam logic [1:0] PC_RIGHT  = 2'd3;

  typedef struct packed {
    logic                  overlap;
    logic                  covered;
    logic [NUM_STRIPS-1:0] strip;
  } rs_flags_t;

endpackage

[src/rs_strips.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rs_strips
// From A's edges and the overlap edges, decides overlap / containment and
// forms the four candidate strips of A around the overlap.
// ---------------------------------------------------------------------------
module rs_strips
  import rs_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic        [COORD_BITS-2:0] a_w,
  input  logic signed [COORD_BITS:0]   a_r,
  input  logic signed [COORD_BITS:0]   a_b,
  input  logic signed [COORD_BITS-1:0] i_x,
  input  logic signed [COORD_BITS-1:0] i_y,
  input  logic signed [COORD_BITS:0]   i_r,
  input  logic signed [COORD_BITS:0]   i_b,
  output rs_flags_t                    flags,
  output logic signed [COORD_BITS-1:0] cand_x [NUM_STRIPS],
  output logic signed [COORD_BITS-1:0] cand_y [NUM_STRIPS],
  output logic        [COORD_BITS-2:0] cand_w [NUM_STRIPS],
  output logic        [COORD_BITS-2:0] cand_h [NUM_STRIPS]
);

  localparam int CW = COORD_BITS;
  localparam int SW = COORD_BITS - 1;

  logic signed [CW:0] ax_ext, ay_ext, ix_ext, iy_ext;
  logic signed [CW:0] d_top, d_left, d_bot, d_right, d_mid;

  assign ax_ext = {a_x[CW-1], a_x};
  assign ay_ext = {a_y[CW-1], a_y};
  assign ix_ext = {i_x[CW-1], i_x};
  assign iy_ext = {i_y[CW-1], i_y};

  // all true sizes fit in SW bits, so the wrapped differences are exact
  assign d_top   = iy_ext - ay_ext;
  assign d_left  = ix_ext - ax_ext;
  assign d_bot   = a_b - i_b;
  assign d_right = a_r - i_r;
  assign d_mid   = i_b - iy_ext;

  always_comb begin
    flags.overlap = (i_r > ix_ext) && (i_b > iy_ext);
    flags.covered = (i_x == a_x) && (i_y == a_y) && (i_r == a_r) && (i_b == a_b);
    flags.strip[PC_TOP]    = i_y > a_y;
    flags.strip[PC_LEFT]   = i_x > a_x;
    flags.strip[PC_BOTTOM] = a_b > i_b;
    flags.strip[PC_RIGHT]  = a_r > i_r;

    cand_x[PC_TOP] = a_x;
    cand_y[PC_TOP] = a_y;
    cand_w[PC_TOP] = a_w;
    cand_h[PC_TOP] = d_top[SW-1:0];

    cand_x[PC_LEFT] = a_x;
    cand_y[PC_LEFT] = i_y;
    cand_w[PC_LEFT] = d_left[SW-1:0];
    cand_h[PC_LEFT] = d_mid[SW-1:0];

    // corners on the overlap's bottom / right edge wrap to CW bits
    cand_x[PC_BOTTOM] = a_x;
    cand_y[PC_BOTTOM] = i_b[CW-1:0];
    cand_w[PC_BOTTOM] = a_w;
    cand_h[PC_BOTTOM] = d_bot[SW-1:0];

    cand_x[PC_RIGHT] = i_r[CW-1:0];
    cand_y[PC_RIGHT] = i_y;
    cand_w[PC_RIGHT] = d_right[SW-1:0];
    cand_h[PC_RIGHT] = d_mid[SW-1:0];
  end

endmodule

[src/rectangle_subtract.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rectangle_subtract
// Difference A minus B of two axis-aligned rectangles, zero to four pieces.
// ---------------------------------------------------------------------------
// An accepted item passes the edge register, the overlap register and the
// output buffer before its first result beat shows. Results leave one beat
// per cycle while out_stall is low: an item gives max(n,1) beats, n being its
// piece count, so the single result channel sets the sustained item rate. The
// next item's set loads in the same cycle the previous set's last beat is
// taken, and up to two further items wait in the pipeline meanwhile.
// Coordinates are signed fixed point with any fraction width; the fraction
// point does not enter the arithmetic.
// ---------------------------------------------------------------------------
module rectangle_subtract
  import rs_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic        [COORD_BITS-2:0] in_a_w,
  input  logic        [COORD_BITS-2:0] in_a_h,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic        [COORD_BITS-2:0] in_b_w,
  input  logic        [COORD_BITS-2:0] in_b_h,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic        [COORD_BITS-2:0] out_w,
  output logic        [COORD_BITS-2:0] out_h,
  output logic                         out_is_empty,
  output logic        [CNT_W-1:0]      out_piece_count,
  output logic                         out_last
);

  localparam int CW = COORD_BITS;
  localparam int SW = COORD_BITS - 1;

  // ---- edge stage
  logic               e_vld_r;
  logic signed [CW-1:0] e_ax_r, e_ay_r, e_bx_r, e_by_r;
  logic        [SW-1:0] e_aw_r, e_ah_r;
  logic signed [CW:0]   e_ar_r, e_ab_r, e_br_r, e_bb_r;

  // ---- overlap stage
  logic               i_vld_r;
  logic signed [CW-1:0] i_ax_r, i_ay_r, i_ix_r, i_iy_r;
  logic        [SW-1:0] i_aw_r, i_ah_r;
  logic signed [CW:0]   i_ar_r, i_ab_r, i_ir_r, i_ib_r;

  // ---- output buffer, slot 0 drives the port
  logic                 buf_vld_r;
  logic signed [CW-1:0] sx_r [NUM_STRIPS];
  logic signed [CW-1:0] sy_r [NUM_STRIPS];
  logic        [SW-1:0] sw_r [NUM_STRIPS];
  logic        [SW-1:0] sh_r [NUM_STRIPS];
  logic [NUM_STRIPS-1:0] slast_r;
  logic                 empty_r;
  logic [CNT_W-1:0]     count_r;

  logic signed [CW-1:0] sx_nxt [NUM_STRIPS];
  logic signed [CW-1:0] sy_nxt [NUM_STRIPS];
  logic        [SW-1:0] sw_nxt [NUM_STRIPS];
  logic        [SW-1:0] sh_nxt [NUM_STRIPS];
  logic [NUM_STRIPS-1:0] slast_nxt;
  logic                 empty_nxt;
  logic [CNT_W-1:0]     count_nxt;

  logic                 out_fire, buf_ld, i_adv_ok, e_ld, i_ld;
  rs_flags_t            flags;
  logic signed [CW-1:0] cand_x [NUM_STRIPS];
  logic signed [CW-1:0] cand_y [NUM_STRIPS];
  logic        [SW-1:0] cand_w [NUM_STRIPS];
  logic        [SW-1:0] cand_h [NUM_STRIPS];

  // ---- flow control
  assign out_fire = buf_vld_r && !out_stall;
  assign buf_ld   = i_vld_r && (!buf_vld_r || (out_fire && slast_r[0]));
  assign i_adv_ok = !i_vld_r || buf_ld;
  assign i_ld     = e_vld_r && i_adv_ok;
  assign in_stall = e_vld_r && !i_adv_ok;
  assign e_ld     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r   <= 1'b0;
      i_vld_r   <= 1'b0;
      buf_vld_r <= 1'b0;
    end else begin
      if (e_ld) begin
        e_vld_r <= 1'b1;
      end else if (i_ld) begin
        e_vld_r <= 1'b0;
      end
      if (i_ld) begin
        i_vld_r <= 1'b1;
      end else if (buf_ld) begin
        i_vld_r <= 1'b0;
      end
      if (buf_ld) begin
        buf_vld_r <= 1'b1;
      end else if (out_fire && slast_r[0]) begin
        buf_vld_r <= 1'b0;
      end
    end
  end

  // ---- edge stage: right and bottom edges at full precision
  always_ff @(posedge clk) begin
    if (e_ld) begin
      e_ax_r <= in_a_x;
      e_ay_r <= in_a_y;
      e_aw_r <= in_a_w;
      e_ah_r <= in_a_h;
      e_bx_r <= in_b_x;
      e_by_r <= in_b_y;
      e_ar_r <= $signed({in_a_x[CW-1], in_a_x}) + $signed({2'b00, in_a_w});
      e_ab_r <= $signed({in_a_y[CW-1], in_a_y}) + $signed({2'b00, in_a_h});
      e_br_r <= $signed({in_b_x[CW-1], in_b_x}) + $signed({2'b00, in_b_w});
      e_bb_r <= $signed({in_b_y[CW-1], in_b_y}) + $signed({2'b00, in_b_h});
    end
  end

  // ---- overlap stage
  always_ff @(posedge clk) begin
    if (i_ld) begin
      i_ax_r <= e_ax_r;
      i_ay_r <= e_ay_r;
      i_aw_r <= e_aw_r;
      i_ah_r <= e_ah_r;
      i_ar_r <= e_ar_r;
      i_ab_r <= e_ab_r;
      i_ix_r <= (e_ax_r > e_bx_r) ? e_ax_r : e_bx_r;
      i_iy_r <= (e_ay_r > e_by_r) ? e_ay_r : e_by_r;
      i_ir_r <= (e_ar_r < e_br_r) ? e_ar_r : e_br_r;
      i_ib_r <= (e_ab_r < e_bb_r) ? e_ab_r : e_bb_r;
    end
  end

  rs_strips #(
    .COORD_BITS (COORD_BITS)
  ) u_strips (
    .a_x    (i_ax_r),
    .a_y    (i_ay_r),
    .a_w    (i_aw_r),
    .a_r    (i_ar_r),
    .a_b    (i_ab_r),
    .i_x    (i_ix_r),
    .i_y    (i_iy_r),
    .i_r    (i_ir_r),
    .i_b    (i_ib_r),
    .flags  (flags),
    .cand_x (cand_x),
    .cand_y (cand_y),
    .cand_w (cand_w),
    .cand_h (cand_h)
  );

  // ---- pack strips into consecutive slots; A if no overlap, empty if covered
  always_comb begin
    logic [CNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < NUM_STRIPS; k++) begin
      sx_nxt[k] = '0;
      sy_nxt[k] = '0;
      sw_nxt[k] = '0;
      sh_nxt[k] = '0;
    end
    slast_nxt = '0;
    empty_nxt = 1'b0;
    if (!flags.overlap) begin
      sx_nxt[0]    = i_ax_r;
      sy_nxt[0]    = i_ay_r;
      sw_nxt[0]    = i_aw_r;
      sh_nxt[0]    = i_ah_r;
      n            = CNT_W'(1);
      slast_nxt[0] = 1'b1;
    end else if (flags.covered) begin
      empty_nxt    = 1'b1;
      slast_nxt[0] = 1'b1;
    end else begin
      for (int k = 0; k < NUM_STRIPS; k++) begin
        if (flags.strip[k]) begin
          sx_nxt[n[1:0]] = cand_x[k];
          sy_nxt[n[1:0]] = cand_y[k];
          sw_nxt[n[1:0]] = cand_w[k];
          sh_nxt[n[1:0]] = cand_h[k];
          n = n + CNT_W'(1);
        end
      end
      for (int k = 0; k < NUM_STRIPS; k++) begin
        slast_nxt[k] = (CNT_W'(k) + CNT_W'(1)) == n;
      end
    end
    count_nxt = n;
  end

  // ---- output buffer: load a whole set, shift one beat per handshake
  always_ff @(posedge clk) begin
    if (buf_ld) begin
      for (int k = 0; k < NUM_STRIPS; k++) begin
        sx_r[k] <= sx_nxt[k];
        sy_r[k] <= sy_nxt[k];
        sw_r[k] <= sw_nxt[k];
        sh_r[k] <= sh_nxt[k];
      end
      slast_r <= slast_nxt;
      empty_r <= empty_nxt;
      count_r <= count_nxt;
    end else if (out_fire) begin
      for (int k = 0; k < NUM_STRIPS - 1; k++) begin
        sx_r[k] <= sx_r[k+1];
        sy_r[k] <= sy_r[k+1];
        sw_r[k] <= sw_r[k+1];
        sh_r[k] <= sh_r[k+1];
      end
      slast_r <= {1'b0, slast_r[NUM_STRIPS-1:1]};
    end
  end

  assign out_valid       = buf_vld_r;
  assign out_x           = sx_r[0];
  assign out_y           = sy_r[0];
  assign out_w           = sw_r[0];
  assign out_h           = sh_r[0];
  assign out_last        = slast_r[0];
  assign out_is_empty    = empty_r;
  assign out_piece_count = count_r;

`include "assert_macros.svh"

  `RS_ASSERT_SAME(a_empty_single, out_valid && out_is_empty, out_last && (out_piece_count == '0), "empty result must be a lone beat with zero count")
  `RS_ASSERT_SAME(a_count_range, out_valid && !out_is_empty, (out_piece_count >= CNT_W'(1)) && (out_piece_count <= CNT_W'(NUM_STRIPS)), "piece count out of range")
  `RS_ASSERT_NEXT(a_set_continues, out_fire && !out_last, out_valid && (out_piece_count == $past(out_piece_count)), "piece set broken off before its last beat")
  `RS_ASSERT_NEXT(a_buf_fills, i_vld_r && !buf_vld_r, buf_vld_r, "idle output buffer failed to take a ready item")

endmodule

[tb/rectangle_subtract_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rectangle_subtract_checker
// Watches both channels of the rectangle difference block. It works out the
// pieces of A minus B for every accepted input beat and compares each
// accepted result beat, field by field, with the oldest piece still due.
// ---------------------------------------------------------------------------
module rectangle_subtract_checker
  import rs_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic        [COORD_BITS-2:0] in_a_w,
  input  logic        [COORD_BITS-2:0] in_a_h,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic        [COORD_BITS-2:0] in_b_w,
  input  logic        [COORD_BITS-2:0] in_b_h,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [COORD_BITS-1:0] out_x,
  input  logic signed [COORD_BITS-1:0] out_y,
  input  logic        [COORD_BITS-2:0] out_w,
  input  logic        [COORD_BITS-2:0] out_h,
  input  logic                         out_is_empty,
  input  logic        [CNT_W-1:0]      out_piece_count,
  input  logic                         out_last,
  output int                           mismatches,
  output int                           pieces_due
);

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-2:0] w;
    logic [COORD_BITS-2:0] h;
    logic                  is_empty;
    logic [CNT_W-1:0]      count;
    logic                  last;
  } piece_t;

  piece_t piece_q[$];

  // corners past the coordinate range wrap to COORD_BITS here
  function automatic piece_t make_piece(longint x, longint y, longint w, longint h);
    piece_t p;
    p.x        = x[COORD_BITS-1:0];
    p.y        = y[COORD_BITS-1:0];
    p.w        = w[COORD_BITS-2:0];
    p.h        = h[COORD_BITS-2:0];
    p.is_empty = 1'b0;
    p.count    = '0;
    p.last     = 1'b0;
    return p;
  endfunction

  function automatic void predict_pieces(
    input logic signed [COORD_BITS-1:0] a_x, a_y,
    input logic        [COORD_BITS-2:0] a_w, a_h,
    input logic signed [COORD_BITS-1:0] b_x, b_y,
    input logic        [COORD_BITS-2:0] b_w, b_h
  );
    longint ax, ay, aw, ah, bx, by, bw, bh;
    longint ar, ab, br, bb, ix, iy, ir, ib;
    piece_t pieces[$];
    ax = longint'(a_x);
    ay = longint'(a_y);
    aw = longint'(a_w);
    ah = longint'(a_h);
    bx = longint'(b_x);
    by = longint'(b_y);
    bw = longint'(b_w);
    bh = longint'(b_h);
    // edges in full precision, held in longint so nothing wraps
    ar = ax + aw;
    ab = ay + ah;
    br = bx + bw;
    bb = by + bh;
    ix = (ax > bx) ? ax : bx;
    iy = (ay > by) ? ay : by;
    ir = (ar < br) ? ar : br;
    ib = (ab < bb) ? ab : bb;
    if (ir - ix <= 0 || ib - iy <= 0) begin
      pieces.push_back(make_piece(ax, ay, aw, ah));
    end else if (ix == ax && iy == ay && ir == ar && ib == ab) begin
      pieces.push_back(make_piece(64'sd0, 64'sd0, 64'sd0, 64'sd0));
      pieces[0].is_empty = 1'b1;
    end else begin
      // top, left, bottom, right; zero-size strips dropped
      if (iy > ay) pieces.push_back(make_piece(ax, ay, aw, iy - ay));
      if (ix > ax) pieces.push_back(make_piece(ax, iy, ix - ax, ib - iy));
      if (ab > ib) pieces.push_back(make_piece(ax, ib, aw, ab - ib));
      if (ar > ir) pieces.push_back(make_piece(ir, iy, ar - ir, ib - iy));
    end
    foreach (pieces[k]) begin
      pieces[k].count = pieces[0].is_empty ? '0 : CNT_W'(pieces.size());
      pieces[k].last  = (k == pieces.size() - 1);
      piece_q.push_back(pieces[k]);
    end
  endfunction

  always @(posedge clk) begin
    piece_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        predict_pieces(in_a_x, in_a_y, in_a_w, in_a_h, in_b_x, in_b_y, in_b_w, in_b_h);
      if (out_valid && !out_stall) begin
        if (piece_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing due: x=%h y=%h w=%h h=%h", $time,
                     out_x, out_y, out_w, out_h);
        end else begin
          want = piece_q.pop_front();
          if (want.x !== out_x || want.y !== out_y || want.w !== out_w ||
              want.h !== out_h || want.is_empty !== out_is_empty ||
              want.count !== out_piece_count || want.last !== out_last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: piece mismatch, expected x=%h y=%h w=%h h=%h empty=%b cnt=%0d last=%b",
                       $time, want.x, want.y, want.w, want.h, want.is_empty, want.count,
                       want.last);
              $display("%0t:                   actual x=%h y=%h w=%h h=%h empty=%b cnt=%0d last=%b",
                       $time, out_x, out_y, out_w, out_h, out_is_empty, out_piece_count,
                       out_last);
            end
          end
        end
      end
    end
    pieces_due = piece_q.size();
  end

endmodule

[tb/rectangle_subtract_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rectangle_subtract_tb
// Drives rectangle pairs into the difference block: a directed set of edge
// cases, then random pairs in three idle/stall phases, one with a long
// result hold-off. The checker predicts and compares; this top gives the
// verdict.
// ---------------------------------------------------------------------------
module rectangle_subtract_tb
  import rs_pkg::*;
();

  localparam int CB              = 32;
  localparam int UNIT            = 65536;
  localparam int LIMIT           = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 120;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CB-1:0] in_a_x;
  logic signed [CB-1:0] in_a_y;
  logic        [CB-2:0] in_a_w;
  logic        [CB-2:0] in_a_h;
  logic signed [CB-1:0] in_b_x;
  logic signed [CB-1:0] in_b_y;
  logic        [CB-2:0] in_b_w;
  logic        [CB-2:0] in_b_h;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [CB-1:0] out_x;
  logic signed [CB-1:0] out_y;
  logic        [CB-2:0] out_w;
  logic        [CB-2:0] out_h;
  logic                 out_is_empty;
  logic    [CNT_W-1:0]  out_piece_count;
  logic                 out_last;

  int mismatches;
  int pieces_due;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  bit hold_req;
  bit hold_done;

  rectangle_subtract #(.COORD_BITS(CB)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_a_x          (in_a_x),
    .in_a_y          (in_a_y),
    .in_a_w          (in_a_w),
    .in_a_h          (in_a_h),
    .in_b_x          (in_b_x),
    .in_b_y          (in_b_y),
    .in_b_w          (in_b_w),
    .in_b_h          (in_b_h),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_w           (out_w),
    .out_h           (out_h),
    .out_is_empty    (out_is_empty),
    .out_piece_count (out_piece_count),
    .out_last        (out_last)
  );

  rectangle_subtract_checker #(.COORD_BITS(CB)) piece_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_a_x          (in_a_x),
    .in_a_y          (in_a_y),
    .in_a_w          (in_a_w),
    .in_a_h          (in_a_h),
    .in_b_x          (in_b_x),
    .in_b_y          (in_b_y),
    .in_b_w          (in_b_w),
    .in_b_h          (in_b_h),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_w           (out_w),
    .out_h           (out_h),
    .out_is_empty    (out_is_empty),
    .out_piece_count (out_piece_count),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .pieces_due      (pieces_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog: cycles without any accepted beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sizes are passed at coordinate width and cut to the port width here
  task automatic offer_rects(
    input logic [CB-1:0] ax, ay,
    input logic [CB-1:0] aw, ah,
    input logic [CB-1:0] bx, by,
    input logic [CB-1:0] bw, bh
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_a_x   <= ax;
    in_a_y   <= ay;
    in_a_w   <= aw[CB-2:0];
    in_a_h   <= ah[CB-2:0];
    in_b_x   <= bx;
    in_b_y   <= by;
    in_b_w   <= bw[CB-2:0];
    in_b_h   <= bh[CB-2:0];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_rects();
    logic [CB-1:0] ax, ay, bx, by;
    logic [CB-1:0] aw, ah, bw, bh;
    int unsigned   d;
    int            pick;
    pick = $urandom_range(99);
    ax = $urandom;
    ay = $urandom;
    bx = $urandom;
    by = $urandom;
    aw = $urandom;
    ah = $urandom;
    bw = $urandom;
    bh = $urandom;
    if (pick < 30) begin
      // coarse grid: shared edges, equal and nested rectangles are common
      ax = (int'($urandom_range(6)) - 3) * UNIT;
      ay = (int'($urandom_range(6)) - 3) * UNIT;
      bx = (int'($urandom_range(6)) - 3) * UNIT;
      by = (int'($urandom_range(6)) - 3) * UNIT;
      aw = $urandom_range(5) * UNIT;
      ah = $urandom_range(5) * UNIT;
      bw = $urandom_range(5) * UNIT;
      bh = $urandom_range(5) * UNIT;
    end else if (pick < 55) begin
      // B near A, partial overlaps
      aw = $urandom_range(1 << 20);
      ah = $urandom_range(1 << 20);
      bw = $urandom_range(1 << 20);
      bh = $urandom_range(1 << 20);
      bx = ax + $urandom_range(1 << 21) - (1 << 20);
      by = ay + $urandom_range(1 << 21) - (1 << 20);
    end else if (pick < 70) begin
      // B covers A, sometimes with shared edges
      ax = $urandom_range(1 << 24) - (1 << 23);
      ay = $urandom_range(1 << 24) - (1 << 23);
      aw = $urandom_range(1 << 20);
      ah = $urandom_range(1 << 20);
      d  = ($urandom_range(3) == 0) ? 0 : $urandom_range(1 << 18);
      bx = ax - d;
      bw = aw + d + (($urandom_range(3) == 0) ? 0 : $urandom_range(1 << 18));
      d  = ($urandom_range(3) == 0) ? 0 : $urandom_range(1 << 18);
      by = ay - d;
      bh = ah + d + (($urandom_range(3) == 0) ? 0 : $urandom_range(1 << 18));
    end else if (pick < 80) begin
      // large sizes, edges often past the coordinate range
      aw = $urandom_range(31'h7fff_ffff, 31'h4000_0000);
      ah = $urandom_range(31'h7fff_ffff, 31'h4000_0000);
      bw = $urandom_range(31'h7fff_ffff, 31'h4000_0000);
      bh = $urandom_range(31'h7fff_ffff, 31'h4000_0000);
    end
    offer_rects(ax, ay, aw, ah, bx, by, bw, bh);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_a_x        <= '0;
    in_a_y        <= '0;
    in_a_w        <= '0;
    in_a_h        <= '0;
    in_b_x        <= '0;
    in_b_y        <= '0;
    in_b_w        <= '0;
    in_b_h        <= '0;
    send_idle_pct = 24;
    recv_idle_pct = 71;
    hold_req      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // disjoint, edges touching, zero-size A and B
    offer_rects(0, 0, 4*UNIT, 4*UNIT, 10*UNIT, 10*UNIT, 2*UNIT, 2*UNIT);
    offer_rects(0, 0, 4*UNIT, 4*UNIT, 4*UNIT, 0, 4*UNIT, 4*UNIT);
    offer_rects(UNIT, UNIT, 0, 2*UNIT, 0, 0, 4*UNIT, 4*UNIT);
    offer_rects(0, 0, 4*UNIT, 4*UNIT, UNIT, UNIT, 0, 0);
    // A equal to B, A inside B, B inside A
    offer_rects(0, 0, 4*UNIT, 4*UNIT, 0, 0, 4*UNIT, 4*UNIT);
    offer_rects(UNIT, UNIT, 2*UNIT, 2*UNIT, 0, 0, 4*UNIT, 4*UNIT);
    offer_rects(0, 0, 8*UNIT, 8*UNIT, 2*UNIT, 2*UNIT, 2*UNIT, 2*UNIT);
    // one strip each: top, left, bottom, right
    offer_rects(0, 0, 4*UNIT, 4*UNIT, -UNIT, 2*UNIT, 6*UNIT, 4*UNIT);
    offer_rects(0, 0, 4*UNIT, 4*UNIT, 2*UNIT, -UNIT, 6*UNIT, 6*UNIT);
    offer_rects(0, 0, 4*UNIT, 4*UNIT, -UNIT, -UNIT, 6*UNIT, 3*UNIT);
    offer_rects(0, 0, 4*UNIT, 4*UNIT, -UNIT, -UNIT, 3*UNIT, 6*UNIT);
    // corner overlap: top and left
    offer_rects(0, 0, 4*UNIT, 4*UNIT, 2*UNIT, 2*UNIT, 4*UNIT, 4*UNIT);
    // field extremes
    offer_rects('0, '0, '0, '0, '0, '0, '0, '0);
    offer_rects('1, '1, '1, '1, '1, '1, '1, '1);
    offer_rects(32'h8000_0000, 32'h8000_0000, '1, '1,
                32'h8000_0000, 32'h8000_0000, UNIT, UNIT);
    offer_rects(32'h7fff_ffff, 32'h7fff_ffff, '1, '1,
                32'h7fff_ffff, 32'h7fff_ffff, 1, 1);
    offer_rects(32'h7fff_ffff, 32'h7fff_ffff, '1, '1,
                32'h8000_0000, 32'h8000_0000, '1, '1);
    // right edge of A past the range: right strip corner wraps
    offer_rects(32'h7fff_0000, 0, '1, 4*UNIT, 32'h7fff_ff00, -UNIT, UNIT, 6*UNIT);

    repeat (ITEMS_PER_PHASE) send_random_rects();

    send_idle_pct = 71;
    recv_idle_pct = 24;
    repeat (ITEMS_PER_PHASE) send_random_rects();

    // no idling; results held off for a while so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    repeat (ITEMS_PER_PHASE) send_random_rects();

    in_valid <= 1'b0;
    while (pieces_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pieces_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/rs_pkg.sv
src/rs_strips.sv
src/rectangle_subtract.sv
tb/rectangle_subtract_checker.sv
tb/rectangle_subtract_tb.sv
